/* rtl/cbse_pkg.sv */
// Package for the Crystal Ball shape evaluator: widths, reset values, register
// and region codes, the side-band struct and the small constant divider.
// No dependencies.
package cbse_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int WIDTH_W     = DATA_WIDTH - 1;
  localparam int SHAPE_W     = 8 + FRAC_BITS;
  localparam int CFG_INDEX_W = 3;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_AMPLITUDE  = 3'd0,
    CFG_PEAK       = 3'd1,
    CFG_WIDTH      = 3'd2,
    CFG_ALPHA      = 3'd3,
    CFG_TAIL_POWER = 3'd4,
    CFG_REFLECT    = 3'd5
  } cbse_cfg_t;

  typedef enum logic [1:0] {
    REGION_CORE  = 2'd0,
    REGION_TAIL  = 2'd1,
    REGION_DEGEN = 2'd2
  } cbse_region_t;

  localparam logic [DATA_WIDTH-1:0] AMPLITUDE_RST  = 32'h0001_0000;
  localparam logic [DATA_WIDTH-1:0] PEAK_RST       = 32'h0000_0000;
  localparam logic [WIDTH_W-1:0]    WIDTH_RST      = 31'h0000_8000;
  localparam logic [SHAPE_W-1:0]    ALPHA_RST      = 24'h01_0000;
  localparam logic [SHAPE_W-1:0]    TAIL_POWER_RST = 24'h0A_0000;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

  // datapath widths
  localparam int D_W     = DATA_WIDTH + 1;            // x' - peak
  localparam int AW_W    = SHAPE_W + WIDTH_W;         // alpha * width
  localparam int TST_W   = AW_W + 2;                  // d*2^F + alpha*width
  localparam int NUM1_W  = D_W + FRAC_BITS;           // numerator of first divide
  localparam int T_W     = FRAC_BITS + 9;             // clamped t
  localparam int S_W     = 38;                        // clamped s
  localparam int SH_W    = S_W / 2;                   // split of s for the product
  localparam int PROD_W  = S_W + SHAPE_W;             // s * alpha
  localparam int LX_W    = PROD_W + 1;                // 1 + v
  localparam int M_W     = 31;                        // log mantissa, Q30 in [1,2)
  localparam int LZ_W    = 6;
  localparam int L_W     = LZ_W + FRAC_BITS;          // log2 result
  localparam int YE_W    = 33;                        // exponent Y
  localparam int Z_W     = 30;
  localparam int TERM_W  = 31;
  localparam int TSUM_W  = 33;
  localparam int G_W     = 31;
  localparam int MAG_W   = DATA_WIDTH + 1;
  localparam int N_TERMS = 12;

  localparam logic [T_W-1:0]   T_MAX      = 25'h100_0000;
  localparam logic [S_W-1:0]   S_MAX      = 38'h3F_FFFF_FFFF;
  localparam logic [LZ_W-1:0]  LOG_INT_TOP = 6'd46;   // msb index of 1+v minus F
  localparam logic [16:0]      EXP_LIMIT  = 17'd40;

  typedef struct packed {
    logic             core;
    logic             degen;
    logic [YE_W-1:0]  ycore;
  } cbse_side_t;

  localparam int SIDE_W = $bits(cbse_side_t);

  // floor(v / i) for i in 1..12, v < 2^30; reciprocals are ceil(2^34 / i)
  function automatic logic [29:0] div_small(input logic [29:0] v, input int unsigned i);
    logic [32:0] r;
    logic [62:0] prod;
    logic [29:0] q;
    r = '0;
    unique case (i)
      3:       r = 33'd5726623062;
      5:       r = 33'd3435973837;
      6:       r = 33'd2863311531;
      7:       r = 33'd2454267027;
      9:       r = 33'd1908874354;
      10:      r = 33'd1717986919;
      11:      r = 33'd1561806290;
      12:      r = 33'd1431655766;
      default: r = '0;
    endcase
    prod = {33'd0, v} * {30'd0, r};
    unique case (i)
      1:       q = v;
      2:       q = v >> 1;
      4:       q = v >> 2;
      8:       q = v >> 3;
      default: q = {1'b0, prod[62:34]};
    endcase
    return q;
  endfunction

endpackage

/* rtl/cbse_stream_if.sv */
// Valid/ready stream interfaces for the shape evaluator: sample in, result out.
// Depends on cbse_pkg.
interface cbse_x_if import cbse_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] x_value;
  modport source (output valid, x_value, input ready);
  modport sink (input valid, x_value, output ready);
endinterface

interface cbse_y_if import cbse_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] y_value;
  logic [1:0]                   region;
  logic                         saturated;
  modport source (output valid, y_value, region, saturated, input ready);
  modport sink (input valid, y_value, region, saturated, output ready);
endinterface

/* rtl/crystal_ball_shape_eval_unit.sv */
// Crystal Ball line shape evaluator, top level: registers, pipeline, output.
// Depends on cbse_pkg, cbse_stream_if (cbse_x_if, cbse_y_if) and cbse_div.
//
// Usage:
//  - sample carries one Q16.16 abscissa per transfer; result returns the
//    Q16.16 value, the region code (core, tail, degenerate) and a saturation
//    flag, one result per sample, in order.
//  - Configuration is a plain write port (cfg_write, cfg_index, cfg_data);
//    write only while no sample is in flight. Unknown indexes are ignored.
//  - Fully pipelined: one sample per cycle sustained while the receiver
//    keeps result.ready high. Depth is set by the two bit-serial dividers
//    (49 and 62 stages), the 16 squaring stages of the log2 and the
//    12-term exponential series at two stages a term.
//  - Reset returns every register to its documented default and empties
//    the pipeline; no sweep is needed.
//  - When the receiver stalls the whole pipeline holds; sample.ready follows
//    result.ready whenever the output register is full, so nothing is lost
//    or repeated.
//  - Derived alpha terms (alpha squared, then its base-2 exponent) are registered
//    after a write, well before any sample reaches the point where they are used.
module crystal_ball_shape_eval_unit import cbse_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  cbse_x_if.sink                 sample,
  cbse_y_if.source               result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]  cfg_data
);

  // ---------------------------------------------------------------- registers
  logic signed [DATA_WIDTH-1:0] amplitude;
  logic signed [DATA_WIDTH-1:0] peak;
  logic [WIDTH_W-1:0]           width;
  logic [SHAPE_W-1:0]           alpha;
  logic [SHAPE_W-1:0]           tail_power;
  logic                         reflect;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude  <= AMPLITUDE_RST;
      peak       <= PEAK_RST;
      width      <= WIDTH_RST;
      alpha      <= ALPHA_RST;
      tail_power <= TAIL_POWER_RST;
      reflect    <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_AMPLITUDE:  amplitude  <= cfg_data;
        CFG_PEAK:       peak       <= cfg_data;
        CFG_WIDTH:      width      <= cfg_data[WIDTH_W-1:0];
        CFG_ALPHA:      alpha      <= cfg_data[SHAPE_W-1:0];
        CFG_TAIL_POWER: tail_power <= cfg_data[SHAPE_W-1:0];
        CFG_REFLECT:    reflect    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // exp(-alpha^2/2) exponent in base 2, same for every sample
  logic [2*SHAPE_W-1:0] alpha_sq;
  logic [61:0]          half_prod;
  logic [31:0]          half_y;

  assign half_prod = {31'd0, alpha_sq[2*SHAPE_W-1:FRAC_BITS+1]} * {31'd0, LOG2E_Q30};

  always_ff @(posedge clk) begin
    alpha_sq <= {24'd0, alpha} * {24'd0, alpha};
    half_y   <= half_prod[61:30];
  end

  // global advance: the pipeline moves unless the output is held
  logic adv;
  assign adv          = !result.valid || result.ready;
  assign sample.ready = adv;

  // ---------------------------------------------------------------- S1: offset
  logic signed [D_W-1:0] x_ext, pk_ext, d_n;
  logic [AW_W-1:0]       aw_n;
  logic                  s1_v;
  logic signed [D_W-1:0] s1_d;
  logic [AW_W-1:0]       s1_aw;

  assign x_ext  = {sample.x_value[DATA_WIDTH-1], sample.x_value};
  assign pk_ext = {peak[DATA_WIDTH-1], peak};
  assign d_n    = reflect ? (pk_ext - x_ext) : (x_ext - pk_ext);  // mirrored: m - x
  assign aw_n   = {31'd0, alpha} * {24'd0, width};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d  <= d_n;
      s1_aw <= aw_n;
    end
  end

  // ---------------------------------------------------------------- S2: core test sum
  logic signed [TST_W-1:0] dd_ext, tsum_n;
  logic [D_W-1:0]          ad_n;
  logic                    s2_v;
  logic signed [TST_W-1:0] s2_sum;
  logic [D_W-1:0]          s2_ad;

  assign dd_ext = {{8{s1_d[D_W-1]}}, s1_d, {FRAC_BITS{1'b0}}};
  assign tsum_n = dd_ext + $signed({2'd0, s1_aw});
  assign ad_n   = s1_d[D_W-1] ? D_W'($unsigned(-s1_d)) : D_W'($unsigned(s1_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sum <= tsum_n;
      s2_ad  <= ad_n;
    end
  end

  // ---------------------------------------------------------------- S3: select numerator
  logic              core_n, degen_n;
  logic [TST_W-1:0]  neg_n;
  logic [NUM1_W-1:0] num1_n;
  logic              s3_v;
  logic [NUM1_W-1:0] s3_num;
  cbse_side_t        s3_side;

  assign core_n  = !s2_sum[TST_W-1] && (s2_sum != '0);
  assign neg_n   = TST_W'($unsigned(-s2_sum));     // tail numerator, never negative here
  assign num1_n  = core_n ? {s2_ad, {FRAC_BITS{1'b0}}} : neg_n[NUM1_W-1:0];
  // zero width; zero alpha in the tail; zero power right at the switch point
  assign degen_n = (width == '0) ||
                   (!core_n && ((alpha == '0) || ((tail_power == '0) && (s2_sum == '0))));

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_num        <= num1_n;
      s3_side.core  <= core_n;
      s3_side.degen <= degen_n;
      s3_side.ycore <= '0;
    end
  end

  // ---------------------------------------------------------------- D1: / width
  logic              d1_v;
  logic [NUM1_W-1:0] d1_q;
  logic [SIDE_W-1:0] d1_tag;
  cbse_side_t        d1_side;

  cbse_div #(.NUM_W(NUM1_W), .DEN_W(WIDTH_W), .TAG_W(SIDE_W)) u_div_width (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s3_v),
    .num       (s3_num),
    .den       (width),
    .tag       (s3_side),
    .out_valid (d1_v),
    .quo       (d1_q),
    .out_tag   (d1_tag)
  );

  assign d1_side = cbse_side_t'(d1_tag);

  // ---------------------------------------------------------------- S4: clamp t and s
  logic             s4_v;
  logic [T_W-1:0]   s4_t;
  logic [S_W-1:0]   s4_s;
  cbse_side_t       s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_t    <= (d1_q > NUM1_W'(T_MAX)) ? T_MAX : d1_q[T_W-1:0];
      s4_s    <= (d1_q > NUM1_W'(S_MAX)) ? S_MAX : d1_q[S_W-1:0];
      s4_side <= d1_side;
    end
  end

  // ---------------------------------------------------------------- S5: t*t, s*alpha halves
  logic                    s5_v;
  logic [2*T_W-1:0]        s5_sq;
  logic [SH_W+SHAPE_W-1:0] s5_plo, s5_phi;
  cbse_side_t              s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sq   <= {25'd0, s4_t} * {25'd0, s4_t};
      s5_plo  <= {24'd0, s4_s[SH_W-1:0]} * {19'd0, alpha};
      s5_phi  <= {24'd0, s4_s[S_W-1:SH_W]} * {19'd0, alpha};
      s5_side <= s4_side;
    end
  end

  // ---------------------------------------------------------------- S6: core exponent, product
  logic [62:0]       ymul_n;
  logic              s6_v;
  logic [PROD_W-1:0] s6_prod;
  cbse_side_t        s6_side;

  // t*t <= 2^48, so h = t*t >> 17 fits 32 bits
  assign ymul_n = {31'd0, s5_sq[2*T_W-2:FRAC_BITS+1]} * {32'd0, LOG2E_Q30};

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (adv) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_prod       <= {s5_phi, {SH_W{1'b0}}} + {{SH_W{1'b0}}, s5_plo};
      s6_side.core  <= s5_side.core;
      s6_side.degen <= s5_side.degen;
      s6_side.ycore <= ymul_n[62:30];
    end
  end

  // ---------------------------------------------------------------- D2: / tail_power
  logic              d2_v;
  logic [PROD_W-1:0] d2_q;
  logic [SIDE_W-1:0] d2_tag;

  cbse_div #(.NUM_W(PROD_W), .DEN_W(SHAPE_W), .TAG_W(SIDE_W)) u_div_power (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s6_v),
    .num       (s6_prod),
    .den       (tail_power),
    .tag       (s6_side),
    .out_valid (d2_v),
    .quo       (d2_q),
    .out_tag   (d2_tag)
  );

  // ---------------------------------------------------------------- log2: normalise
  // leading-one search on 1 + v, six shift stages of 32, 16 ... 1
  logic              nm_v    [LZ_W];
  logic [LX_W-1:0]   nm_x    [LZ_W];
  logic [LZ_W-1:0]   nm_lz   [LZ_W];
  cbse_side_t        nm_side [LZ_W];

  for (genvar j = 0; j < LZ_W; j++) begin : g_norm
    localparam int SH = 32 >> j;
    logic            pv;
    logic [LX_W-1:0] px;
    logic [LZ_W-1:0] plz;
    cbse_side_t      pside;
    logic            top_zero;

    if (j == 0) begin : g_first
      assign pv    = d2_v;
      assign px    = {1'b0, d2_q} + (LX_W'(1) << FRAC_BITS);
      assign plz   = '0;
      assign pside = cbse_side_t'(d2_tag);
    end else begin : g_next
      assign pv    = nm_v[j-1];
      assign px    = nm_x[j-1];
      assign plz   = nm_lz[j-1];
      assign pside = nm_side[j-1];
    end

    assign top_zero = (px[LX_W-1 -: SH] == '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        nm_v[j] <= 1'b0;
      end else if (adv) begin
        nm_v[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        nm_x[j]    <= top_zero ? (px << SH) : px;
        nm_lz[j]   <= top_zero ? (plz + LZ_W'(SH)) : plz;
        nm_side[j] <= pside;
      end
    end
  end

  // ---------------------------------------------------------------- log2: squaring
  logic                 sq_v    [FRAC_BITS];
  logic [M_W-1:0]       sq_m    [FRAC_BITS];
  logic [FRAC_BITS-1:0] sq_frac [FRAC_BITS];
  logic [LZ_W-1:0]      sq_ip   [FRAC_BITS];
  cbse_side_t           sq_side [FRAC_BITS];

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_square
    logic                 pv;
    logic [M_W-1:0]       pm;
    logic [FRAC_BITS-1:0] pfrac;
    logic [LZ_W-1:0]      pip;
    cbse_side_t           pside;
    logic [2*M_W-1:0]     mm;
    logic [M_W:0]         up;
    logic [FRAC_BITS-1:0] nfrac;

    if (i == 0) begin : g_first
      assign pv    = nm_v[LZ_W-1];
      assign pm    = nm_x[LZ_W-1][LX_W-1 -: M_W];
      assign pfrac = '0;
      assign pip   = LOG_INT_TOP - nm_lz[LZ_W-1];
      assign pside = nm_side[LZ_W-1];
    end else begin : g_next
      assign pv    = sq_v[i-1];
      assign pm    = sq_m[i-1];
      assign pfrac = sq_frac[i-1];
      assign pip   = sq_ip[i-1];
      assign pside = sq_side[i-1];
    end

    assign mm = {31'd0, pm} * {31'd0, pm};
    assign up = mm[2*M_W-1:30];

    always_comb begin
      nfrac = pfrac;
      nfrac[FRAC_BITS-1-i] = up[M_W];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[i] <= 1'b0;
      end else if (adv) begin
        sq_v[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_m[i]    <= up[M_W] ? up[M_W:1] : up[M_W-1:0];
        sq_frac[i] <= nfrac;
        sq_ip[i]   <= pip;
        sq_side[i] <= pside;
      end
    end
  end

  // ---------------------------------------------------------------- T1: n * log2(1 + v)
  logic [L_W-1:0]         log_n;
  logic                   t1_v;
  logic [SHAPE_W+L_W-1:0] t1_nl;
  cbse_side_t             t1_side;

  assign log_n = {sq_ip[FRAC_BITS-1], sq_frac[FRAC_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
    end else if (adv) begin
      t1_v <= sq_v[FRAC_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_nl   <= {22'd0, tail_power} * {24'd0, log_n};
      t1_side <= sq_side[FRAC_BITS-1];
    end
  end

  // ---------------------------------------------------------------- T2: exponent Y
  logic [YE_W-1:0] pow_n, ye_n;
  logic            t2_v;
  logic [YE_W-1:0] t2_ye;
  cbse_side_t      t2_side;

  // n = 0 leaves the power factor at one
  assign pow_n = (tail_power == '0) ? '0 : {3'd0, t1_nl[SHAPE_W+L_W-1:FRAC_BITS]};
  assign ye_n  = t1_side.core ? t1_side.ycore : ({1'b0, half_y} + pow_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_v <= 1'b0;
    end else if (adv) begin
      t2_v <= t1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_ye   <= ye_n;
      t2_side <= t1_side;
    end
  end

  // ---------------------------------------------------------------- E0: split 2^-Y
  logic [16:0]  k_n;
  logic [45:0]  zp_n;
  logic         e0_v;
  logic [Z_W-1:0] e0_z;
  logic [5:0]   e0_k;
  logic         e0_kbig;
  cbse_side_t   e0_side;

  assign k_n  = t2_ye[YE_W-1:FRAC_BITS];
  assign zp_n = {30'd0, t2_ye[FRAC_BITS-1:0]} * {16'd0, LN2_Q30};

  always_ff @(posedge clk) begin
    if (rst) begin
      e0_v <= 1'b0;
    end else if (adv) begin
      e0_v <= t2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e0_z    <= zp_n[45:FRAC_BITS];
      e0_k    <= k_n[5:0];
      e0_kbig <= (k_n >= EXP_LIMIT);
      e0_side <= t2_side;
    end
  end

  // ---------------------------------------------------------------- exp(-z) series
  // two stages a term: term*z, then /i and accumulate with alternating sign
  logic                     ta_v    [N_TERMS];
  logic [TERM_W+Z_W-1:0]    ta_p    [N_TERMS];
  logic signed [TSUM_W-1:0] ta_sum  [N_TERMS];
  logic [Z_W-1:0]           ta_z    [N_TERMS];
  logic [5:0]               ta_k    [N_TERMS];
  logic                     ta_kbig [N_TERMS];
  cbse_side_t               ta_side [N_TERMS];

  logic                     tb_v    [N_TERMS];
  logic [TERM_W-1:0]        tb_term [N_TERMS];
  logic signed [TSUM_W-1:0] tb_sum  [N_TERMS];
  logic [Z_W-1:0]           tb_z    [N_TERMS];
  logic [5:0]               tb_k    [N_TERMS];
  logic                     tb_kbig [N_TERMS];
  cbse_side_t               tb_side [N_TERMS];

  for (genvar i = 0; i < N_TERMS; i++) begin : g_series
    localparam bit SUBTRACT = ((i % 2) == 0);   // odd powers of z subtract
    logic                     pv;
    logic [TERM_W-1:0]        pterm;
    logic signed [TSUM_W-1:0] psum;
    logic [Z_W-1:0]           pz;
    logic [5:0]               pk;
    logic                     pkbig;
    cbse_side_t               pside;
    logic [29:0]              quot;
    logic signed [TSUM_W-1:0] term_ext;

    if (i == 0) begin : g_first
      assign pv    = e0_v;
      assign pterm = ONE_Q30;
      assign psum  = $signed({2'd0, ONE_Q30});
      assign pz    = e0_z;
      assign pk    = e0_k;
      assign pkbig = e0_kbig;
      assign pside = e0_side;
    end else begin : g_next
      assign pv    = tb_v[i-1];
      assign pterm = tb_term[i-1];
      assign psum  = tb_sum[i-1];
      assign pz    = tb_z[i-1];
      assign pk    = tb_k[i-1];
      assign pkbig = tb_kbig[i-1];
      assign pside = tb_side[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ta_v[i] <= 1'b0;
        tb_v[i] <= 1'b0;
      end else if (adv) begin
        ta_v[i] <= pv;
        tb_v[i] <= ta_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ta_p[i]    <= {30'd0, pterm} * {31'd0, pz};
        ta_sum[i]  <= psum;
        ta_z[i]    <= pz;
        ta_k[i]    <= pk;
        ta_kbig[i] <= pkbig;
        ta_side[i] <= pside;
      end
    end

    // term*z < 2^60, so the scaled product fits 30 bits
    assign quot     = div_small(ta_p[i][59:30], i + 1);
    assign term_ext = $signed({3'd0, quot});

    always_ff @(posedge clk) begin
      if (adv) begin
        tb_term[i] <= {1'b0, quot};
        tb_sum[i]  <= SUBTRACT ? (ta_sum[i] - term_ext) : (ta_sum[i] + term_ext);
        tb_z[i]    <= ta_z[i];
        tb_k[i]    <= ta_k[i];
        tb_kbig[i] <= ta_kbig[i];
        tb_side[i] <= ta_side[i];
      end
    end
  end

  // ---------------------------------------------------------------- X0: clamp, shift by k
  logic [G_W-1:0] g_n;
  logic           x0_v;
  logic [G_W-1:0] x0_g;
  cbse_side_t     x0_side;

  assign g_n = tb_sum[N_TERMS-1][TSUM_W-1] ? '0 : tb_sum[N_TERMS-1][G_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      x0_v <= 1'b0;
    end else if (adv) begin
      x0_v <= tb_v[N_TERMS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_g    <= tb_kbig[N_TERMS-1] ? '0 : (g_n >> tb_k[N_TERMS-1]);
      x0_side <= tb_side[N_TERMS-1];
    end
  end

  // ---------------------------------------------------------------- X1: scale by |amplitude|
  logic [DATA_WIDTH-1:0] amag;
  logic [62:0]           mp_n;
  logic                  x1_v;
  logic [MAG_W-1:0]      x1_mag;
  cbse_side_t            x1_side;

  assign amag = amplitude[DATA_WIDTH-1] ? DATA_WIDTH'($unsigned(-amplitude))
                                        : DATA_WIDTH'($unsigned(amplitude));
  assign mp_n = {31'd0, amag} * {32'd0, x0_g};

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_v <= 1'b0;
    end else if (adv) begin
      x1_v <= x0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_mag  <= mp_n[62:30];
      x1_side <= x0_side;
    end
  end

  // ---------------------------------------------------------------- output register
  localparam logic [MAG_W-1:0]      POS_LIMIT = 33'h0_7FFF_FFFF;
  localparam logic [MAG_W-1:0]      NEG_LIMIT = 33'h0_8000_0000;
  localparam logic [DATA_WIDTH-1:0] Y_MAX     = 32'h7FFF_FFFF;
  localparam logic [DATA_WIDTH-1:0] Y_MIN     = 32'h8000_0000;

  logic [DATA_WIDTH-1:0] y_n;
  logic [1:0]            region_n;
  logic                  sat_n;

  always_comb begin
    y_n      = '0;
    region_n = REGION_DEGEN;
    sat_n    = 1'b0;
    if (!x1_side.degen) begin
      region_n = x1_side.core ? REGION_CORE : REGION_TAIL;
      if (!amplitude[DATA_WIDTH-1]) begin
        if (x1_mag > POS_LIMIT) begin
          y_n   = Y_MAX;
          sat_n = 1'b1;
        end else begin
          y_n = x1_mag[DATA_WIDTH-1:0];
        end
      end else begin
        if (x1_mag > NEG_LIMIT) begin
          y_n   = Y_MIN;
          sat_n = 1'b1;
        end else begin
          y_n = ~x1_mag[DATA_WIDTH-1:0] + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= x1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.y_value   <= y_n;
      result.region    <= region_n;
      result.saturated <= sat_n;
    end
  end

endmodule

/* rtl/cbse_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a side-band tag.
// No dependencies. The divisor must stay stable while items are in flight.
module cbse_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 31,
  parameter int TAG_W = 35
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo,
  output logic [TAG_W-1:0] out_tag
);

  logic             vld [NUM_W];
  logic [DEN_W-1:0] rem [NUM_W];
  logic [NUM_W-1:0] nq  [NUM_W];   // remaining numerator bits, quotient shifts in
  logic [TAG_W-1:0] tg  [NUM_W];

  for (genvar j = 0; j < NUM_W; j++) begin : g_stage
    logic             pv;
    logic [DEN_W-1:0] prem;
    logic [NUM_W-1:0] pnq;
    logic [TAG_W-1:0] ptg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             qbit;

    if (j == 0) begin : g_first
      assign pv   = in_valid;
      assign prem = '0;
      assign pnq  = num;
      assign ptg  = tag;
    end else begin : g_next
      assign pv   = vld[j-1];
      assign prem = rem[j-1];
      assign pnq  = nq[j-1];
      assign ptg  = tg[j-1];
    end

    assign trial = {prem, pnq[NUM_W-1]};
    assign diff  = trial - {1'b0, den};
    assign qbit  = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq[j]  <= {pnq[NUM_W-2:0], qbit};
        tg[j]  <= ptg;
      end
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign quo       = nq[NUM_W-1];
  assign out_tag   = tg[NUM_W-1];

endmodule

/* test/cbse_tb_if.sv */
`timescale 1ns / 1ps
// Testbench-side note: the stream interfaces live with the RTL (cbse_stream_if.sv).
// This file holds the transfer record used by the bench. Depends on cbse_pkg.
package cbse_tb_pkg;
  import cbse_pkg::*;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] y_value;
    cbse_region_t                 region;
    logic                         saturated;
  } shape_result_t;
endpackage

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Crystal Ball shape evaluator bench: directed and random samples under several
// register settings, results checked against an in-bench fixed-point predictor.
// Depends on cbse_pkg, cbse_tb_pkg, cbse_stream_if and the RTL.
module tb_top;
  import cbse_pkg::*;
  import cbse_tb_pkg::*;

  localparam int PIPE_LAT = 169;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DATA_WIDTH-1:0] cfg_data = '0;

  cbse_x_if sample ();
  cbse_y_if result ();

  crystal_ball_shape_eval_unit uut (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the registers
  logic [63:0] m_amp, m_peak, m_width, m_alpha, m_power, m_reflect;

  shape_result_t expected_q[$];
  int err_count = 0;
  int sent = 0;
  int got = 0;

  task automatic report(input string what);
    $display("MISMATCH %0s at result %0d", what, got);
    err_count++;
  endtask

  // 2^-y, y in Q16, result Q30
  function automatic logic [63:0] pow2_neg(input logic [63:0] y);
    logic [63:0] k, f, z, term;
    longint sum;
    k = y >> FRAC_BITS;
    f = y & 64'hFFFF;
    if (k >= 40) return 0;
    term = 64'd1 << 30;
    sum = longint'(64'd1 << 30);
    z = (f * 64'd744261118) >> FRAC_BITS;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * z) >> 30) / i;
      if (i % 2) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    return 64'(sum) >> k;
  endfunction

  function automatic logic [63:0] log2_q16(input logic [63:0] v);
    int p;
    logic [63:0] mm, frac;
    p = 63;
    frac = 0;
    while (p > 0 && !v[p]) p--;
    if (p < FRAC_BITS) return 0;
    mm = (p > 30) ? (v >> (p - 30)) : (v << (30 - p));
    for (int i = 1; i <= FRAC_BITS; i++) begin
      mm = (mm * mm) >> 30;
      if (mm >= (64'd2 << 30)) begin
        mm >>= 1;
        frac |= 64'd1 << (FRAC_BITS - i);
      end
    end
    return (64'(p - FRAC_BITS) << FRAC_BITS) | frac;
  endfunction

  function automatic shape_result_t predict_shape(input logic [DATA_WIDTH-1:0] xin);
    shape_result_t r;
    longint x, mk, a, xe, d, dd, aw, yv;
    logic [63:0] ye, g, amag, mag, ad, t, h, s_num, half, s, v, l;
    r.y_value = '0;
    r.region = REGION_DEGEN;
    r.saturated = 1'b0;
    x = longint'($signed(xin));
    mk = longint'($signed(m_peak[31:0]));
    a = longint'($signed(m_amp[31:0]));
    xe = m_reflect[0] ? 2 * mk - x : x;
    d = xe - mk;
    dd = d * 65536;
    aw = longint'(m_alpha * m_width);
    if (m_width == 0) return r;
    if (dd > -aw) begin
      ad = 64'(d < 0 ? -d : d);
      t = (ad << FRAC_BITS) / m_width;
      if (t > (64'd1 << 24)) t = 64'd1 << 24;
      h = (t * t) >> 17;
      ye = (h * 64'd1549082005) >> 30;
      r.region = REGION_CORE;
    end else begin
      s_num = 64'(-dd - aw);
      half = (m_alpha * m_alpha) >> 17;
      if (m_alpha == 0) return r;
      if (m_power == 0 && s_num == 0) return r;
      ye = (half * 64'd1549082005) >> 30;
      if (m_power != 0) begin
        s = s_num / m_width;
        if (s > (64'd1 << 38) - 1) s = (64'd1 << 38) - 1;
        v = (s * m_alpha) / m_power;
        l = log2_q16(v + 64'h10000);
        ye += (m_power * l) >> FRAC_BITS;
      end
      r.region = REGION_TAIL;
    end
    g = pow2_neg(ye);
    amag = 64'(a < 0 ? -a : a);
    mag = (amag * g) >> 30;
    yv = a < 0 ? -longint'(mag) : longint'(mag);
    if (yv > 64'sd2147483647) begin
      yv = 64'sd2147483647;
      r.saturated = 1'b1;
    end else if (yv < -64'sd2147483648) begin
      yv = -64'sd2147483648;
      r.saturated = 1'b1;
    end
    r.y_value = yv[31:0];
    return r;
  endfunction

  // drop sample valid once a burst is over
  task automatic idle_x();
    if (sample.valid) sample.valid <= 1'b0;
  endtask

  // register write at one edge once the pipe is empty, bench copy follows
  task automatic write_reg(input cbse_cfg_t idx, input logic [DATA_WIDTH-1:0] val);
    idle_x();
    while (expected_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    unique case (idx)
      CFG_AMPLITUDE:  m_amp = 64'(val);
      CFG_PEAK:       m_peak = 64'(val);
      CFG_WIDTH:      m_width = 64'(val[WIDTH_W-1:0]);
      CFG_ALPHA:      m_alpha = 64'(val[SHAPE_W-1:0]);
      CFG_TAIL_POWER: m_power = 64'(val[SHAPE_W-1:0]);
      CFG_REFLECT:    m_reflect = 64'(val[0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // one sample transfer with a random lead-in gap; valid stays up back to back
  task automatic send_x(input logic [DATA_WIDTH-1:0] xv);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.x_value <= xv;
    do @(posedge clk); while (!sample.ready);
    expected_q.push_back(predict_shape(xv));
    sent++;
  endtask

  task automatic drain_results();
    idle_x();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  // random sample, mostly near the peak so core and tail both get hit
  function automatic logic [31:0] pick_x();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return $urandom();
    if (sel < 8) return m_peak[31:0] + 32'($signed($urandom_range(0, 32'h0010_0000))
                                            - 32'sh0008_0000);
    return m_peak[31:0] + 32'($signed($urandom_range(0, 32'h0400_0000))
                              - 32'sh0200_0000);
  endfunction

  task automatic test_reset_values();
    m_amp = 64'(AMPLITUDE_RST);
    m_peak = 64'(PEAK_RST);
    m_width = 64'(WIDTH_RST);
    m_alpha = 64'(ALPHA_RST);
    m_power = 64'(TAIL_POWER_RST);
    m_reflect = 64'd1;
    send_x(32'h0000_0000);
    send_x(32'h0000_8000);
    send_x(32'hFFFF_8000);
    send_x(32'h7FFF_FFFF);
    send_x(32'h8000_0000);
    send_x(32'h0001_0000);
    send_x(32'hFFFF_0000);
    send_x(32'h0000_0001);
    drain_results();
  endtask

  task automatic test_special_cases();
    // tail boundary exactly, then zero tail power at and past it
    write_reg(CFG_REFLECT, 0);
    write_reg(CFG_WIDTH, 32'h0001_0000);
    send_x(32'hFFFF_0000);
    send_x(32'hFFF0_0000);
    write_reg(CFG_TAIL_POWER, 0);
    send_x(32'hFFFF_0000);
    send_x(32'hFFF0_0000);
    write_reg(CFG_ALPHA, 0);
    send_x(32'hFFF0_0000);
    send_x(32'h0000_0000);
    drain_results();
    write_reg(CFG_WIDTH, 0);
    send_x(32'h1234_5678);
    send_x(32'h8000_0000);
    drain_results();
    // extreme shape and amplitude values
    write_reg(CFG_WIDTH, 32'h7FFF_FFFF);
    write_reg(CFG_ALPHA, 32'hFF_FFFF);
    write_reg(CFG_TAIL_POWER, 32'hFF_FFFF);
    write_reg(CFG_AMPLITUDE, 32'h8000_0000);
    write_reg(CFG_PEAK, 32'h7FFF_FFFF);
    send_x(32'h8000_0000);
    send_x(32'h7FFF_FFFF);
    write_reg(CFG_WIDTH, 1);
    write_reg(CFG_ALPHA, 1);
    write_reg(CFG_TAIL_POWER, 1);
    write_reg(CFG_AMPLITUDE, 32'h7FFF_FFFF);
    write_reg(CFG_PEAK, 32'h8000_0000);
    send_x(32'h8000_0000);
    send_x(32'h7FFF_FFFF);
    send_x(32'h8000_0100);
    drain_results();
  endtask

  task automatic test_random_settings(input int n_items);
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_AMPLITUDE, ($urandom_range(0, 3) == 0) ? $urandom() :
                {{15{1'b0}}, 17'($urandom())} * (($urandom_range(0, 1)) ? 1 : -1));
      write_reg(CFG_PEAK, ($urandom_range(0, 1)) ? $urandom() : $urandom_range(0, 32'h000F_FFFF));
      write_reg(CFG_WIDTH, ($urandom_range(0, 4) == 0) ? ($urandom() >> 1)
                : $urandom_range(32'h0000_1000, 32'h0008_0000));
      write_reg(CFG_ALPHA, ($urandom_range(0, 4) == 0) ? $urandom()
                : $urandom_range(32'h0000_2000, 32'h0004_0000));
      write_reg(CFG_TAIL_POWER, ($urandom_range(0, 4) == 0) ? $urandom()
                : $urandom_range(32'h0000_1000, 32'h0020_0000));
      write_reg(CFG_REFLECT, $urandom_range(0, 1));
      for (int i = 0; i < n_items / 8; i++) begin
        send_x(pick_x());
        // sender hold-off until the pipe has fully emptied
        if (i == n_items / 16 && ph == 3) begin
          idle_x();
          while (expected_q.size() != 0) @(posedge clk);
        end
      end
      drain_results();
    end
  endtask

  // result side: random stalls, compare against the oldest expectation
  initial begin
    shape_result_t exp_r;
    int stall;
    result.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
      if (expected_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        exp_r = expected_q.pop_front();
        if (result.y_value !== exp_r.y_value)
          report($sformatf("y_value got %h want %h", result.y_value, exp_r.y_value));
        if (result.region !== exp_r.region)
          report($sformatf("region got %0d want %0d", result.region, exp_r.region));
        if (result.saturated !== exp_r.saturated)
          report($sformatf("saturated got %b want %b", result.saturated, exp_r.saturated));
      end
      got++;
    end
  end

  initial begin
    sample.valid = 1'b0;
    sample.x_value = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_special_cases();
    test_random_settings(1320);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

/* sim.f */
rtl/cbse_pkg.sv
rtl/cbse_stream_if.sv
rtl/cbse_div.sv
rtl/crystal_ball_shape_eval_unit.sv
test/cbse_tb_if.sv
test/tb_top.sv
